>>> design/stt_pkg.sv
// Shared types and constants of the software timer table.
package stt_pkg;

	localparam int unsigned TIMER_SLOTS_DEF = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned REM_W = 33;
	localparam int unsigned SLOT_OUT_W = 4;

	localparam logic KIND_REL = 1'b0;
	localparam logic KIND_ABS = 1'b1;

	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_REMOVE = 2'd1,
		FN_TICK = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_FULL = 3'd1,
		ST_REMOVED = 3'd2,
		ST_NOT_ACTIVE = 3'd3,
		ST_REARMED = 3'd4,
		ST_FREED = 3'd5,
		ST_DONE = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_REMOVE,
		S_TICK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic kind;
		logic rep;
		logic [TIME_W-1:0] reload;
		logic [REM_W-1:0] rem;
	} entry_t;

	typedef struct packed {
		logic fire;
		logic keep;
		logic [REM_W-1:0] rem;
	} upd_t;

	typedef struct packed {
		logic valid;
		status_t status;
		logic [SLOT_OUT_W-1:0] slot;
		logic last;
	} res_t;

endpackage

>>> design/software_timer_table.sv
// Top level of the software timer table: stream ports, entry RAM and result register.
//
// A table of TIMER_SLOTS one-shot or periodic timers. Each input transfer is
// taken only while the sequencer is idle; a result register lets the next
// transfer in while the last result still waits downstream. An add scans the
// slot valid bits one per cycle from slot 0 until it finds a free slot or
// reaches the last, a remove frees the named slot if it is active, and a tick
// walks every slot through the entry RAM read port at one slot per cycle while
// the result side does not stall it, then gives a done result. No clearing
// pass follows reset: the slot valid bits clear at once and an entry is only
// used once an add has written it. A write with cfg_wen loads cfg_wdata as the
// previous tick time used by the next tick.
module software_timer_table #(
	parameter int unsigned TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// timeout_value[31:0], repeat_on_fire[32], slot_index[36:33], now_time[68:37], zero pad
	input  logic [71:0] s_axis_tdata,
	// func[1:0], timer_kind[2]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// slot[3:0], zero pad
	output logic [7:0]  m_axis_tdata,
	// status[2:0]
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int unsigned SW = $clog2(TIMER_SLOTS);

	logic out_valid_q;
	stt_pkg::status_t status_q;
	logic [stt_pkg::SLOT_OUT_W-1:0] slot_q;
	logic last_q;
	logic out_free;
	stt_pkg::res_t res;

	logic [SW-1:0] mem_rd_addr;
	logic [SW-1:0] mem_wr_addr;
	logic mem_we;
	stt_pkg::entry_t mem_rd_data;
	stt_pkg::entry_t mem_wr_data;

	assign out_free = !out_valid_q || m_axis_tready;

	stt_ctrl #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_func     (s_axis_tuser[1:0]),
		.in_kind     (s_axis_tuser[2]),
		.in_value    (s_axis_tdata[31:0]),
		.in_rep      (s_axis_tdata[32]),
		.in_idx      (s_axis_tdata[36:33]),
		.in_now      (s_axis_tdata[68:37]),
		.out_free    (out_free),
		.res         (res),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_we      (mem_we),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	stt_ram #(
		.WIDTH ($bits(stt_pkg::entry_t)),
		.DEPTH (TIMER_SLOTS)
	) u_entry_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			slot_q <= res.slot;
			last_q <= res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0000, slot_q};
	assign m_axis_tuser = status_q;
	assign m_axis_tlast = last_q;

endmodule

>>> design/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/stt_update.sv
// Tick evaluation of one timer entry: saturating countdown of relative timers and fire decision.
module stt_update (
	input  stt_pkg::entry_t              entry,
	input  logic [stt_pkg::REM_W-1:0]    elapsed,
	input  logic [stt_pkg::TIME_W-1:0]   now,
	output stt_pkg::upd_t                upd
);

	logic [stt_pkg::REM_W:0]   diff;
	logic [stt_pkg::REM_W-1:0] rem_sat;
	logic                      rel_fire;
	logic                      abs_fire;

	always_comb begin
		diff = {entry.rem[stt_pkg::REM_W-1], entry.rem} - {elapsed[stt_pkg::REM_W-1], elapsed};
		case (diff[stt_pkg::REM_W:stt_pkg::REM_W-1])
			2'b10: rem_sat = {1'b1, {stt_pkg::TIME_W{1'b0}}};
			2'b01: rem_sat = {1'b0, {stt_pkg::TIME_W{1'b1}}};
			default: rem_sat = diff[stt_pkg::REM_W-1:0];
		endcase
		rel_fire = rem_sat[stt_pkg::REM_W-1] || (rem_sat == '0);
		abs_fire = entry.reload <= now;
		if (entry.kind == stt_pkg::KIND_REL) begin
			upd.fire = rel_fire;
			upd.keep = !rel_fire || entry.rep;
			upd.rem = (rel_fire && entry.rep) ? {1'b0, entry.reload} : rem_sat;
		end else begin
			upd.fire = abs_fire;
			upd.keep = !abs_fire;
			upd.rem = entry.rem;
		end
	end

endmodule

>>> design/stt_ctrl.sv
// Sequencer of the timer table: slot valid bits, slot scans and result generation.
module stt_ctrl #(
	parameter int unsigned TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF,
	localparam int unsigned SW = $clog2(TIMER_SLOTS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [stt_pkg::TIME_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 in_func,
	input  logic                       in_kind,
	input  logic [stt_pkg::TIME_W-1:0] in_value,
	input  logic                       in_rep,
	input  logic [3:0]                 in_idx,
	input  logic [stt_pkg::TIME_W-1:0] in_now,
	input  logic                       out_free,
	output stt_pkg::res_t              res,
	output logic [SW-1:0]              mem_rd_addr,
	input  stt_pkg::entry_t            mem_rd_data,
	output logic                       mem_we,
	output logic [SW-1:0]              mem_wr_addr,
	output stt_pkg::entry_t            mem_wr_data
);

	localparam int unsigned IW = (SW > 4) ? SW : 4;

	stt_pkg::state_t state_q, state_d;
	logic [SW-1:0] cnt_q, cnt_d;
	logic [TIMER_SLOTS-1:0] active_q, active_d;
	logic [stt_pkg::TIME_W-1:0] prev_q;
	logic [stt_pkg::REM_W-1:0] elapsed_q;
	logic [stt_pkg::TIME_W-1:0] now_q;
	logic [stt_pkg::TIME_W-1:0] value_q;
	logic kind_q;
	logic rep_q;
	logic [3:0] idx_q;

	logic [IW:0] idx_wide;
	logic idx_in_range;
	logic [SW-1:0] idx_sel;
	logic cnt_last;
	logic tick_fire;
	logic advance;
	logic accept;
	stt_pkg::upd_t upd;

	stt_update u_update (
		.entry   (mem_rd_data),
		.elapsed (elapsed_q),
		.now     (now_q),
		.upd     (upd)
	);

	assign accept = in_valid && in_ready;
	assign idx_wide = (IW+1)'(idx_q);
	assign idx_in_range = idx_wide < (IW+1)'(TIMER_SLOTS);
	assign idx_sel = idx_wide[SW-1:0];
	assign cnt_last = cnt_q == SW'(TIMER_SLOTS - 1);
	assign tick_fire = active_q[cnt_q] && upd.fire;
	assign advance = !tick_fire || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::S_IDLE;
			cnt_q <= '0;
			active_q <= '0;
			prev_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			active_q <= active_d;
			if (cfg_wen) begin
				prev_q <= cfg_wdata;
			end else if (accept && in_func == stt_pkg::FN_TICK) begin
				prev_q <= in_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			value_q <= in_value;
			rep_q <= in_rep;
			idx_q <= in_idx;
			now_q <= in_now;
			elapsed_q <= {1'b0, in_now} - {1'b0, prev_q};
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		active_d = active_q;
		in_ready = 1'b0;
		res = '0;
		mem_rd_addr = '0;
		mem_we = 1'b0;
		mem_wr_addr = cnt_q;
		mem_wr_data = '{kind: mem_rd_data.kind, rep: mem_rd_data.rep,
			reload: mem_rd_data.reload, rem: upd.rem};
		case (state_q)
			stt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cnt_d = '0;
				if (in_valid) begin
					case (stt_pkg::func_t'(in_func))
						stt_pkg::FN_ADD: state_d = stt_pkg::S_ADD;
						stt_pkg::FN_REMOVE: state_d = stt_pkg::S_REMOVE;
						stt_pkg::FN_TICK: state_d = stt_pkg::S_TICK;
						default: state_d = stt_pkg::S_IDLE;
					endcase
				end
			end
			stt_pkg::S_ADD: begin
				if (!active_q[cnt_q]) begin
					if (out_free) begin
						mem_we = 1'b1;
						mem_wr_data = '{kind: kind_q, rep: rep_q, reload: value_q,
							rem: {1'b0, value_q}};
						active_d[cnt_q] = 1'b1;
						res = '{valid: 1'b1, status: stt_pkg::ST_ADDED,
							slot: stt_pkg::SLOT_OUT_W'(cnt_q), last: 1'b1};
						state_d = stt_pkg::S_IDLE;
					end
				end else if (cnt_last) begin
					if (out_free) begin
						res = '{valid: 1'b1, status: stt_pkg::ST_FULL, slot: '0, last: 1'b1};
						state_d = stt_pkg::S_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			stt_pkg::S_REMOVE: begin
				if (out_free) begin
					if (idx_in_range && active_q[idx_sel]) begin
						active_d[idx_sel] = 1'b0;
						res = '{valid: 1'b1, status: stt_pkg::ST_REMOVED, slot: idx_q,
							last: 1'b1};
					end else begin
						res = '{valid: 1'b1, status: stt_pkg::ST_NOT_ACTIVE, slot: idx_q,
							last: 1'b1};
					end
					state_d = stt_pkg::S_IDLE;
				end
			end
			stt_pkg::S_TICK: begin
				mem_rd_addr = (advance && !cnt_last) ? cnt_q + 1'b1 : cnt_q;
				if (advance) begin
					if (active_q[cnt_q]) begin
						mem_we = mem_rd_data.kind == stt_pkg::KIND_REL;
						if (!upd.keep) begin
							active_d[cnt_q] = 1'b0;
						end
					end
					if (tick_fire) begin
						res = '{valid: 1'b1,
							status: upd.keep ? stt_pkg::ST_REARMED : stt_pkg::ST_FREED,
							slot: stt_pkg::SLOT_OUT_W'(cnt_q), last: 1'b0};
					end
					cnt_d = cnt_q + 1'b1;
					if (cnt_last) begin
						state_d = stt_pkg::S_DONE;
					end
				end
			end
			stt_pkg::S_DONE: begin
				if (out_free) begin
					res = '{valid: 1'b1, status: stt_pkg::ST_DONE, slot: '0, last: 1'b1};
					state_d = stt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = stt_pkg::S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result produced while output register is occupied");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == stt_pkg::S_ADD || state_q == stt_pkg::S_TICK))
		else $error("entry write outside add or tick");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_func == stt_pkg::FN_TICK) |=> (state_q == stt_pkg::S_TICK && cnt_q == '0))
		else $error("tick did not start at slot zero");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last) |=> state_q == stt_pkg::S_IDLE)
		else $error("sequencer busy after final result");

	a_add_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == stt_pkg::ST_ADDED) |=> $countones(active_q) ==
		$countones($past(active_q)) + 1)
		else $error("add did not claim exactly one slot");
`endif

endmodule
